// ----- design/ctl_pkg.sv -----
// package for the config text lexer: result type, lexer modes, event codes
// and position helpers; no dependencies
package ctl_pkg;

  localparam int POS_BITS = 16;
  localparam int OUT_POS_BITS = 16;
  localparam int RES_DEPTH = 3;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [31:0] OUT_POS_MAX = 32'((64'd1 << OUT_POS_BITS) - 64'd1);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD = 2'd1,
    MODE_COMMENT = 2'd2,
    MODE_ENDED = 2'd3
  } lex_mode_t;

  typedef enum logic [2:0] {
    EV_WORD_BYTE = 3'd0,
    EV_WORD_END = 3'd1,
    EV_LBRACE = 3'd2,
    EV_RBRACE = 3'd3,
    EV_SEMI = 3'd4,
    EV_EOF = 3'd5
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0] word_char;
    logic first;
    logic [OUT_POS_BITS-1:0] line;
    logic [OUT_POS_BITS-1:0] column;
    logic last;
  } res_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    sat_inc = (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [OUT_POS_BITS-1:0] clip_pos(input logic [POS_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    clip_pos = (ext > OUT_POS_MAX) ? OUT_POS_MAX[OUT_POS_BITS-1:0] : ext[OUT_POS_BITS-1:0];
  endfunction

  function automatic res_t mk_res(input event_kind_t kind, input logic [7:0] ch,
                                  input logic first, input logic [POS_BITS-1:0] line,
                                  input logic [POS_BITS-1:0] column);
    res_t r;
    r.kind = kind;
    r.word_char = (kind == EV_WORD_BYTE) ? ch : 8'h00;
    r.first = (kind == EV_WORD_BYTE) ? first : 1'b0;
    r.line = clip_pos(line);
    r.column = clip_pos(column);
    r.last = 1'b0;
    mk_res = r;
  endfunction

endpackage

// ----- design/config_text_lexer.sv -----
// config text lexer top level: byte classifier, position counters and result queue
// depends on ctl_pkg
//
//  channel | dir | tdata                                       | tuser            | tlast
//  in_     | in  | [7:0] text_byte                             | -                | final_byte
//  out_    | out | [7:0] word_char [23:8] line [39:24] column  | [2:0] kind [3] first | last_of_run
//
// one byte beat per cycle while out_tready is high and each byte gives at most one
// result; a byte that gives two or three results holds in_tready low until the three-entry
// result queue has drained down to its final entry, one result per cycle while out_tready is high.
// rst_n is synchronous: mode goes to between tokens, line and column to 1, queue empties.
// a stalled output keeps its beat; input is taken while the last queued result leaves.
module config_text_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // word_char, token_line, token_column
  output logic [3:0]  out_tuser,  // event_kind, first_of_word
  output logic        out_tlast   // last_of_run
);
  import ctl_pkg::*;

  lex_mode_t mode_r, mode_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;
  logic [POS_BITS-1:0] wsc_r, wsc_nxt;
  res_t res_q_r [RES_DEPTH];
  res_t res_q_nxt [RES_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;

  res_t gen [RES_DEPTH];
  logic [1:0] gen_cnt;
  lex_mode_t gen_mode;
  logic [POS_BITS-1:0] gen_line, gen_col, gen_wsc;

  logic in_fire, out_fire;
  logic b_space, b_nl, b_hash, b_sym, b_nul, b_delim;

  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_fire = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_fire = out_tvalid && out_tready;

  assign out_tdata = {res_q_r[0].column, res_q_r[0].line, res_q_r[0].word_char};
  assign out_tuser = {res_q_r[0].first, res_q_r[0].kind};
  assign out_tlast = res_q_r[0].last;

  assign b_space = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB) || (in_tdata == CH_VT) ||
                   (in_tdata == CH_FF) || (in_tdata == CH_CR);
  assign b_nl = (in_tdata == CH_NL);
  assign b_hash = (in_tdata == CH_HASH);
  assign b_sym = (in_tdata == CH_LBRACE) || (in_tdata == CH_RBRACE) || (in_tdata == CH_SEMI);
  assign b_nul = (in_tdata == CH_NUL);
  assign b_delim = b_space || b_nl || b_hash || b_sym;

  always_comb begin
    event_kind_t sym_kind;
    logic do_start;
    gen_mode = mode_r;
    gen_line = line_r;
    gen_col = col_r;
    gen_wsc = wsc_r;
    gen_cnt = 2'd0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      gen[i] = '0;
    end
    sym_kind = (in_tdata == CH_LBRACE) ? EV_LBRACE :
               (in_tdata == CH_RBRACE) ? EV_RBRACE : EV_SEMI;
    do_start = (mode_r == MODE_BETWEEN) || ((mode_r == MODE_WORD) && b_delim);

    if (mode_r == MODE_WORD) begin
      if (b_delim) begin
        gen[gen_cnt] = mk_res(EV_WORD_END, 8'h00, 1'b0, gen_line, gen_wsc);
        gen_cnt = gen_cnt + 2'd1;
        gen_mode = MODE_BETWEEN;
      end else begin
        gen[gen_cnt] = mk_res(EV_WORD_BYTE, in_tdata, 1'b0, gen_line, gen_wsc);
        gen_cnt = gen_cnt + 2'd1;
        gen_col = sat_inc(gen_col);
      end
    end
    if ((mode_r == MODE_COMMENT) && b_nl) begin
      gen_line = sat_inc(gen_line);
      gen_col = POS_ONE;
      gen_mode = MODE_BETWEEN;
    end

    if (do_start) begin
      if (b_space) begin
        gen_col = sat_inc(gen_col);
      end else if (b_nl) begin
        gen_line = sat_inc(gen_line);
        gen_col = POS_ONE;
      end else if (b_nul) begin
        gen[gen_cnt] = mk_res(EV_EOF, 8'h00, 1'b0, gen_line, gen_col);
        gen_cnt = gen_cnt + 2'd1;
        gen_mode = MODE_ENDED;
      end else if (b_hash) begin
        gen_mode = MODE_COMMENT;
      end else if (b_sym) begin
        gen[gen_cnt] = mk_res(sym_kind, 8'h00, 1'b0, gen_line, gen_col);
        gen_cnt = gen_cnt + 2'd1;
        gen_col = sat_inc(gen_col);
      end else begin
        gen_wsc = gen_col;
        gen[gen_cnt] = mk_res(EV_WORD_BYTE, in_tdata, 1'b1, gen_line, gen_col);
        gen_cnt = gen_cnt + 2'd1;
        gen_col = sat_inc(gen_col);
        gen_mode = MODE_WORD;
      end
    end

    if (in_tlast) begin
      if (gen_mode == MODE_WORD) begin
        gen[gen_cnt] = mk_res(EV_WORD_END, 8'h00, 1'b0, gen_line, gen_wsc);
        gen_cnt = gen_cnt + 2'd1;
        gen[gen_cnt] = mk_res(EV_EOF, 8'h00, 1'b0, gen_line, gen_wsc);
        gen_cnt = gen_cnt + 2'd1;
      end else if (gen_mode != MODE_ENDED) begin
        gen[gen_cnt] = mk_res(EV_EOF, 8'h00, 1'b0, gen_line, gen_col);
        gen_cnt = gen_cnt + 2'd1;
      end
      gen_mode = MODE_BETWEEN;
      gen_line = POS_ONE;
      gen_col = POS_ONE;
      gen_wsc = POS_ONE;
    end

    if (gen_cnt != 2'd0) begin
      gen[gen_cnt - 2'd1].last = 1'b1;
    end
  end

  // next state and result queue
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt = col_r;
    wsc_nxt = wsc_r;
    res_q_nxt = res_q_r;
    cnt_nxt = cnt_r;
    if (out_fire) begin
      res_q_nxt[0] = res_q_r[1];
      res_q_nxt[1] = res_q_r[2];
      cnt_nxt = cnt_r - 2'd1;
    end
    if (in_fire) begin
      mode_nxt = gen_mode;
      line_nxt = gen_line;
      col_nxt = gen_col;
      wsc_nxt = gen_wsc;
      if (gen_cnt != 2'd0) begin
        res_q_nxt = gen;
        cnt_nxt = gen_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      line_r <= POS_ONE;
      col_r <= POS_ONE;
      wsc_r <= POS_ONE;
      cnt_r <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      wsc_r <= wsc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_q_r <= res_q_nxt;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 || cnt_r == 2'd3 && out_tvalid)
    else $error("result count out of step with valid");

  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_q_r[cnt_r - 2'd1].last)
    else $error("final queued result lacks last flag");

  a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= 2'd2) |-> !res_q_r[0].last)
    else $error("last flag set before the end of a run");

  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (mode_r == MODE_BETWEEN && line_r == POS_ONE && col_r == POS_ONE))
    else $error("state not restored after final byte");

  a_word_col: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_WORD) |-> (col_r > wsc_r || col_r == POS_MAX))
    else $error("column not past word start inside a word");
`endif

endmodule
